### rtl/lcwc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcwc_pkg: shared types and constants
// Widths, register indexes and the front-to-back job record.
// ----------------------------------------------------------------------------
package lcwc_pkg;

    localparam int MEDIAN_TAPS_DEF  = 9;
    localparam int AVERAGE_TAPS_DEF = 40;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam int SW = 24;   // sample word width
    localparam int OW = 26;   // offset width
    localparam int WW = 36;   // fine weight width

    localparam logic [2:0] REG_SCALE     = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_TICKS     = 3'd2;
    localparam logic [2:0] REG_BAND      = 3'd3;
    localparam logic [2:0] REG_STEP      = 3'd4;

    localparam logic [OW-1:0] OFFSET_MAX = 26'h1FF_FFFF;
    localparam logic [OW-1:0] OFFSET_MIN = 26'h200_0000;

    typedef struct packed {
        logic          tare;
        logic [SW-1:0] value;   // sign-extended sample or tare value
    } job_t;

endpackage
`default_nettype wire

### rtl/lcwc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcwc_front: intake and classification
// Sign-extends converter words, drops rejected codes and queues jobs.
// ----------------------------------------------------------------------------
module lcwc_front
    import lcwc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic          opcode,
    input  wire logic [SW-1:0] raw_code,
    input  wire logic [SW-1:0] tare_counts,
    output job_t               job,
    output logic               job_valid,
    input  wire logic          job_take
);
    localparam int QD = 2;

    job_t       q_reg [QD];
    logic [0:0] wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic [SAMPLE_BITS-1:0] s;
    logic [SW-1:0] sx;
    logic       reject, acc, keep;

    // classify
    always_comb
    begin
        s  = raw_code[SAMPLE_BITS-1:0];
        sx = SW'($signed(s));
        reject = (s == '0) || (s == '1) ||
                 (s == {1'b0, {(SAMPLE_BITS-1){1'b1}}}) ||
                 (s == {1'b1, {(SAMPLE_BITS-1){1'b0}}});
    end

    assign full      = (cnt_reg == 2'(QD));
    assign acc       = push && !full;
    assign keep      = acc && (opcode || !reject);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_reg];

    // hold queued jobs
    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            q_reg[wr_reg].tare  <= opcode;
            q_reg[wr_reg].value <= opcode ? tare_counts : sx;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (keep)
                wr_reg <= wr_reg + 1'b1;
            if (job_take && job_valid)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(keep) - 2'(job_take && job_valid);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !keep) else $error("queue overflow");
    a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job_valid) else $error("take from empty queue");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QD)) else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

### rtl/lcwc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcwc_back: filter and weighing engine
// Median by rank counting, moving average with serial divide, weighing and
// zero tracking, one job at a time.
// ----------------------------------------------------------------------------
module lcwc_back
    import lcwc_pkg::*;
#(
    parameter int MEDIAN_TAPS  = MEDIAN_TAPS_DEF,
    parameter int AVERAGE_TAPS = AVERAGE_TAPS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire job_t          job,
    input  wire logic          job_valid,
    output logic               job_take,
    input  wire logic [23:0]   cfg_scale,
    input  wire logic [15:0]   cfg_threshold,
    input  wire logic [7:0]    cfg_ticks,
    input  wire logic [15:0]   cfg_band,
    input  wire logic [15:0]   cfg_step,
    output logic               empty,
    input  wire logic          pop,
    output logic [15:0]        weight_grams,
    output logic [WW-1:0]      weight_fine,
    output logic [SW-1:0]      filtered_counts,
    output logic               is_stable,
    output logic [OW-1:0]      current_offset
);
    localparam int MI = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
    localparam int MC = $clog2(MEDIAN_TAPS + 1);
    localparam int AI = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
    localparam int AC = $clog2(AVERAGE_TAPS + 1);
    localparam int SUMW = SW + AC + 1;
    localparam int DW = SUMW + 1;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_TARE = 4'd1, ST_AVRD = 4'd2,
        ST_MED = 4'd3, ST_AVG = 4'd4, ST_DIV = 4'd5, ST_SUB = 4'd6,
        ST_MUL = 4'd7, ST_WGT = 4'd8, ST_TRK = 4'd9, ST_OUT = 4'd10;

    logic [3:0]  st_reg;
    logic [SW-1:0] med_reg [MEDIAN_TAPS];
    logic [MC-1:0] mfill_reg;
    logic [MI-1:0] mpos_reg;
    logic [SW-1:0] amem [AVERAGE_TAPS];
    logic [SW-1:0] ard_reg;
    logic [AC-1:0] afill_reg;
    logic [AI-1:0] apos_reg;
    logic [SUMW-1:0] sum_reg;
    logic [OW-1:0] off_reg;
    logic [WW-1:0] prev_reg;
    logic [7:0]  run_reg;
    logic [AI-1:0] tidx_reg;
    logic [MI-1:0] ci_reg;
    logic [SW-1:0] med_val_reg;
    logic [SW-1:0] s_reg;
    // divider
    logic [DW-1:0] rem_reg, quo_reg;
    logic        neg_reg;
    logic [6:0]  dcnt_reg;
    logic [SW-1:0] avg_reg;
    logic [OW:0] diff_reg;
    logic signed [OW+SW:0] prod_reg;
    logic [WW-1:0] w_reg;
    logic        stab_reg;
    // output stage
    logic        ovalid_reg;
    logic [15:0] og_reg;
    logic [WW-1:0] ow_reg;
    logic [SW-1:0] oa_reg;
    logic        os_reg;
    logic [OW-1:0] oo_reg;

    // rank of candidate ci within the window: count less and less-or-equal
    logic [MC-1:0] nlt, nle;
    logic [SW-1:0] cand;
    always_comb
    begin
        cand = med_reg[ci_reg];
        nlt = '0;
        nle = '0;
        for (int k = 0; k < MEDIAN_TAPS; k++)
        begin
            if (MC'(k) < mfill_reg)
            begin
                if ($signed(med_reg[k]) < $signed(cand)) nlt = nlt + 1'b1;
                if ($signed(med_reg[k]) <= $signed(cand)) nle = nle + 1'b1;
            end
        end
    end
    logic [MC-1:0] mid;
    assign mid = mfill_reg >> 1;

    logic [SUMW-1:0] sabs;
    logic [DW-1:0] trial;
    assign sabs  = sum_reg[SUMW-1] ? -sum_reg : sum_reg;
    assign trial = {rem_reg[DW-2:0], quo_reg[DW-1]} - DW'(afill_reg);

    logic signed [WW-1:0] wsh, dlt, adlt, aw;
    logic [7:0] run_n;
    logic       stab_n;
    logic signed [OW+1:0] offn;
    always_comb
    begin
        wsh  = WW'(prod_reg >>> 16);
        dlt  = wsh - $signed(prev_reg);
        adlt = dlt[WW-1] ? -dlt : dlt;
        run_n = run_reg;
        if (adlt < $signed({20'd0, cfg_threshold}))
        begin
            if (run_reg < cfg_ticks) run_n = run_reg + 1'b1;
        end
        else
            run_n = '0;
        stab_n = (run_n >= cfg_ticks);
        aw = w_reg[WW-1] ? -$signed(w_reg) : $signed(w_reg);
        offn = (OW+2)'($signed(off_reg));
        if (stab_reg && aw < $signed({20'd0, cfg_band}))
        begin
            if ($signed(avg_reg) > $signed(off_reg))
                offn = offn + $signed({2'b0, 10'd0, cfg_step});
            else if ($signed(avg_reg) < $signed(off_reg))
                offn = offn - $signed({2'b0, 10'd0, cfg_step});
        end
    end

    assign job_take = (st_reg == ST_IDLE) && job_valid && !ovalid_reg;
    assign empty = !ovalid_reg;
    assign weight_grams = og_reg;
    assign weight_fine = ow_reg;
    assign filtered_counts = oa_reg;
    assign is_stable = os_reg;
    assign current_offset = oo_reg;

    // average window memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_TARE)
            amem[tidx_reg] <= s_reg;
        else if (st_reg == ST_AVG)
            amem[apos_reg] <= med_val_reg;
        ard_reg <= amem[apos_reg];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (job_take)
            s_reg <= job.value;
        if (st_reg == ST_MED && nlt <= mid && mid < nle)
            med_val_reg <= cand;
        if (st_reg == ST_SUB)
            diff_reg <= (OW+1)'($signed(avg_reg)) - (OW+1)'($signed(off_reg));
        if (st_reg == ST_MUL)
            prod_reg <= $signed(diff_reg) * $signed(cfg_scale);
        if (st_reg == ST_WGT)
            w_reg <= wsh;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            for (int k = 0; k < MEDIAN_TAPS; k++) med_reg[k] <= '0;
            mfill_reg <= '0; mpos_reg <= '0;
            afill_reg <= '0; apos_reg <= '0; sum_reg <= '0;
            off_reg <= '0; prev_reg <= '0; run_reg <= '0;
            tidx_reg <= '0; ci_reg <= '0;
            rem_reg <= '0; quo_reg <= '0; neg_reg <= 1'b0; dcnt_reg <= '0;
            avg_reg <= '0; stab_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            og_reg <= '0; ow_reg <= '0; oa_reg <= '0; os_reg <= 1'b0; oo_reg <= '0;
        end
        else
        begin
            if (pop && ovalid_reg)
                ovalid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (job_take)
                    begin
                        tidx_reg <= '0;
                        st_reg <= job.tare ? ST_TARE : ST_AVRD;
                    end
                end
                ST_TARE:
                begin
                    // fill the average memory, one entry a cycle
                    for (int k = 0; k < MEDIAN_TAPS; k++) med_reg[k] <= s_reg;
                    if (tidx_reg == AI'(AVERAGE_TAPS - 1))
                    begin
                        off_reg <= OW'($signed(s_reg));
                        mfill_reg <= MC'(MEDIAN_TAPS); mpos_reg <= '0;
                        afill_reg <= AC'(AVERAGE_TAPS); apos_reg <= '0;
                        sum_reg <= SUMW'($signed(s_reg)) * SUMW'(AVERAGE_TAPS);
                        st_reg <= ST_IDLE;
                    end
                    else
                        tidx_reg <= tidx_reg + 1'b1;
                end
                ST_AVRD:
                begin
                    // insert into median window
                    med_reg[mpos_reg] <= s_reg;
                    mpos_reg <= (mpos_reg == MI'(MEDIAN_TAPS - 1)) ? '0 : mpos_reg + 1'b1;
                    if (mfill_reg < MC'(MEDIAN_TAPS)) mfill_reg <= mfill_reg + 1'b1;
                    ci_reg <= '0;
                    st_reg <= ST_MED;
                end
                ST_MED:
                begin
                    if (MC'(ci_reg) + 1'b1 >= mfill_reg)
                        st_reg <= ST_AVG;
                    else
                        ci_reg <= ci_reg + 1'b1;
                end
                ST_AVG:
                begin
                    if (afill_reg == AC'(AVERAGE_TAPS))
                        sum_reg <= sum_reg - SUMW'($signed(ard_reg))
                                   + SUMW'($signed(med_val_reg));
                    else
                    begin
                        sum_reg <= sum_reg + SUMW'($signed(med_val_reg));
                        afill_reg <= afill_reg + 1'b1;
                    end
                    apos_reg <= (apos_reg == AI'(AVERAGE_TAPS - 1)) ? '0 : apos_reg + 1'b1;
                    dcnt_reg <= 7'(DW + 1);
                    st_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    // restoring divide, one quotient bit a cycle
                    if (dcnt_reg == 7'(DW + 1))
                    begin
                        neg_reg <= sum_reg[SUMW-1];
                        quo_reg <= DW'(sabs);
                        rem_reg <= '0;
                        dcnt_reg <= dcnt_reg - 1'b1;
                    end
                    else if (dcnt_reg != '0)
                    begin
                        if (!trial[DW-1])
                        begin
                            rem_reg <= trial;
                            quo_reg <= {quo_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[DW-2:0], quo_reg[DW-1]};
                            quo_reg <= {quo_reg[DW-2:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - 1'b1;
                    end
                    else
                    begin
                        avg_reg <= neg_reg ? SW'(-quo_reg) : SW'(quo_reg);
                        st_reg <= ST_SUB;
                    end
                end
                ST_SUB: st_reg <= ST_MUL;
                ST_MUL: st_reg <= ST_WGT;
                ST_WGT:
                begin
                    run_reg <= run_n;
                    stab_reg <= stab_n;
                    prev_reg <= wsh;
                    st_reg <= ST_TRK;
                end
                ST_TRK:
                begin
                    if (offn > $signed({2'b00, OFFSET_MAX}))
                        off_reg <= OFFSET_MAX;
                    else if (offn < $signed({2'b11, OFFSET_MIN}))
                        off_reg <= OFFSET_MIN;
                    else
                        off_reg <= OW'(offn);
                    st_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        og_reg <= w_reg[WW-1] ? 16'd0 :
                                  (w_reg[WW-2:24] != '0) ? 16'hFFFF : w_reg[23:8];
                        ow_reg <= w_reg;
                        oa_reg <= avg_reg;
                        os_reg <= stab_reg;
                        oo_reg <= off_reg;
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> st_reg != ST_IDLE) else $error("job taken but engine idle");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        afill_reg <= AC'(AVERAGE_TAPS)) else $error("average fill overrun");
    a_mfill: assert property (@(posedge clk) disable iff (!rst_n)
        mfill_reg <= MC'(MEDIAN_TAPS)) else $error("median fill overrun");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !pop) |=> ovalid_reg) else $error("result lost");
`endif
endmodule
`default_nettype wire

### rtl/load_cell_weight_conditioner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// load_cell_weight_conditioner: load-cell filter and weigh top level
// Median, moving average, weight conversion and zero tracking.
// ----------------------------------------------------------------------------
// Path: median insert and rank-count scan, average update, restoring divide,
//   subtract, multiply, weigh, zero tracking and output, one state after another.
// Flow: one item at a time in the engine, the next taken only after the result
//   is popped; two-entry queue in front.
// Tare: refills the median window and average memory, sets the offset, no result.
// Reset: asynchronous, clears state, registers to defaults, queue empty.
module load_cell_weight_conditioner
    import lcwc_pkg::*;
#(
    parameter int MEDIAN_TAPS  = MEDIAN_TAPS_DEF,
    parameter int AVERAGE_TAPS = AVERAGE_TAPS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic          opcode,
    input  wire logic [SW-1:0] raw_code,
    input  wire logic [SW-1:0] tare_counts,
    output logic               empty,
    input  wire logic          pop,
    output logic [15:0]        weight_grams,
    output logic [WW-1:0]      weight_fine,
    output logic [SW-1:0]      filtered_counts,
    output logic               is_stable,
    output logic [OW-1:0]      current_offset,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [23:0]   cfg_data
);
    logic [23:0] scale_reg;
    logic [15:0] thr_reg, band_reg, step_reg;
    logic [7:0]  ticks_reg;
    job_t        job;
    logic        job_valid, job_take;

    assign cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 24'd79400;
            thr_reg   <= 16'd512;
            ticks_reg <= 8'd12;
            band_reg  <= 16'd1280;
            step_reg  <= 16'd20;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCALE:     scale_reg <= cfg_data;
                REG_THRESHOLD: thr_reg   <= cfg_data[15:0];
                REG_TICKS:     ticks_reg <= cfg_data[7:0];
                REG_BAND:      band_reg  <= cfg_data[15:0];
                REG_STEP:      step_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    lcwc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .opcode(opcode),
        .raw_code(raw_code), .tare_counts(tare_counts),
        .job(job), .job_valid(job_valid), .job_take(job_take)
    );

    lcwc_back #(.MEDIAN_TAPS(MEDIAN_TAPS), .AVERAGE_TAPS(AVERAGE_TAPS)) u_back (
        .clk(clk), .rst_n(rst_n), .job(job), .job_valid(job_valid),
        .job_take(job_take), .cfg_scale(scale_reg), .cfg_threshold(thr_reg),
        .cfg_ticks(ticks_reg), .cfg_band(band_reg), .cfg_step(step_reg),
        .empty(empty), .pop(pop), .weight_grams(weight_grams),
        .weight_fine(weight_fine), .filtered_counts(filtered_counts),
        .is_stable(is_stable), .current_offset(current_offset)
    );
endmodule
`default_nettype wire
